/* rtl/core/binary_morphology_filter_core_macros.svh */
// assertion macros for the binary morphology filter core
`ifndef BINARY_MORPHOLOGY_FILTER_CORE_MACROS_SVH
`define BINARY_MORPHOLOGY_FILTER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BMF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmf assertion failed");
`define BMF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmf assertion failed");
`else
`define BMF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BMF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/bmf_pkg.sv */
// shared types and constants of the binary morphology filter
package bmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int OROW_W     = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;
    localparam int STORE_ROWS = 4;
    localparam int SLOT_W     = $clog2(STORE_ROWS);
    localparam int ADDR_W     = SLOT_W + COL_W;
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PIX_W-1:0] PIX_ONE  = 8'hFF;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] out_pixel;
        logic             last_of_frame;
    } t_out_beat;

    typedef struct packed {
        logic              wr_en;
        logic              wr_bit;
        logic [SLOT_W-1:0] wr_row;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_row_mid;
        logic [SLOT_W-1:0] rd_row_top;
        logic [COL_W-1:0]  col;
    } t_lb_req;

endpackage

/* rtl/core/bmf_line_buf.sv */
// row store of binary pixels: one write port, two registered read ports
module bmf_line_buf (
    input  logic              i_clk,
    input  bmf_pkg::t_lb_req  i_req,
    output logic              o_rd_mid,
    output logic              o_rd_top
);

    logic r_mem [0:(1 << bmf_pkg::ADDR_W)-1];
    logic r_rd_mid;
    logic r_rd_top;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[{i_req.wr_row, i_req.col}] <= i_req.wr_bit;
        end
        if (i_req.rd_en) begin
            r_rd_mid <= r_mem[{i_req.rd_row_mid, i_req.col}];
            r_rd_top <= r_mem[{i_req.rd_row_top, i_req.col}];
        end
    end

    assign o_rd_mid = r_rd_mid;
    assign o_rd_top = r_rd_top;

endmodule

/* rtl/core/binary_morphology_filter_core.sv */
// binary 3x3 erosion/dilation filter over a raster pixel stream
// an accepted beat is registered in stage 1 (with the row store reads), then in the result register
// throughput: one beat per cycle unless the output stalls, limited by the line buffer ports
// results trail the input stream by width+1 beats; drain beats flush the tail
// reset (sync, active low) clears counters and pipeline valids, sets mode to erode and width, height to max
// row store is not cleared by reset; rows not yet written are read but masked out of the result
`include "binary_morphology_filter_core_macros.svh"

module binary_morphology_filter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bmf_pkg::t_in_beat                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bmf_pkg::t_out_beat                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [bmf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bmf_pkg::CFG_W-1:0]         i_cfg_data
);

    // configuration
    logic                        r_mode;
    logic [bmf_pkg::DIM_W-1:0]   r_width;
    logic [bmf_pkg::DIM_W-1:0]   r_height;
    logic [bmf_pkg::DIM_W-1:0]   n_dim;

    // raster counters
    logic [bmf_pkg::COL_W-1:0]   r_in_col,  n_in_col;
    logic [bmf_pkg::DIM_W-1:0]   r_in_row,  n_in_row;
    logic [bmf_pkg::COL_W-1:0]   r_out_col, n_out_col;
    logic [bmf_pkg::OROW_W-1:0]  r_out_row, n_out_row;

    // stage 1
    logic                        r_s1_valid;
    logic                        r_s1_bit;
    logic                        r_s1_emit;
    logic                        r_s1_last;
    logic                        r_s1_top_ok;
    logic                        r_s1_bot_ok;
    logic                        r_s1_left_ok;
    logic                        r_s1_right_ok;

    // window columns and result register
    logic [2:0]                  r_win_l;
    logic [2:0]                  r_win_c;
    logic                        r_out_valid;
    bmf_pkg::t_out_beat          r_out_data;

    logic                        acc, in_frame, drop, adv, cur_bit;
    logic                        emit, is_last, col_end, s1_go, s1_fire;
    logic [bmf_pkg::SLOT_W-1:0]  slot;
    bmf_pkg::t_lb_req            lb_req;
    logic                        rd_mid, rd_top;
    logic [2:0]                  win_r, row_m, m_l, m_r;
    logic                        all_set, any_set, win_res;

    // input side
    assign s1_go      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_go;
    assign acc        = i_in_valid && o_in_ready;
    assign in_frame   = r_in_row < r_height;
    assign drop       = in_frame && (i_in_data.op == bmf_pkg::OP_DRAIN);
    assign adv        = acc && !drop;
    assign cur_bit    = (r_mode == bmf_pkg::MODE_DILATE) ? (i_in_data.pixel != bmf_pkg::PIX_ZERO)
                                                         : (i_in_data.pixel == bmf_pkg::PIX_ONE);
    assign emit       = (|r_in_row[bmf_pkg::DIM_W-1:1])
                        || (r_in_row[0] && (r_in_col != '0));
    assign is_last    = emit && ({1'b0, r_out_row} == r_height - 1'b1)
                        && ({1'b0, r_out_col} == r_width - 1'b1);
    assign col_end    = ({1'b0, r_in_col} == r_width - 1'b1);
    assign slot       = r_in_row[bmf_pkg::SLOT_W-1:0];

    always_comb begin
        lb_req.wr_en      = adv && in_frame;
        lb_req.wr_bit     = cur_bit;
        lb_req.wr_row     = slot;
        lb_req.rd_en      = adv;
        lb_req.rd_row_mid = slot - bmf_pkg::SLOT_W'(1);
        lb_req.rd_row_top = slot - bmf_pkg::SLOT_W'(2);
        lb_req.col        = r_in_col;
    end

    bmf_line_buf u_line_buf (
        .i_clk    (i_clk),
        .i_req    (lb_req),
        .o_rd_mid (rd_mid),
        .o_rd_top (rd_top)
    );

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_cfg_we && (i_cfg_index != bmf_pkg::CFG_IDX_W'(3))) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (adv) begin
            if (is_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (col_end) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + 1'b1;
                end else begin
                    n_in_col = r_in_col + 1'b1;
                end
                if (emit) begin
                    if ({1'b0, r_out_col} == r_width - 1'b1) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = r_out_col + 1'b1;
                    end
                end
            end
        end
    end

    // clamp a written dimension to 1..max
    always_comb begin
        if (i_cfg_data == '0) begin
            n_dim = bmf_pkg::DIM_W'(1);
        end else if (i_cfg_data > bmf_pkg::CFG_W'(bmf_pkg::MAX_WIDTH)) begin
            n_dim = bmf_pkg::DIM_W'(bmf_pkg::MAX_WIDTH);
        end else begin
            n_dim = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= bmf_pkg::MODE_ERODE;
            r_width  <= bmf_pkg::DIM_W'(bmf_pkg::MAX_WIDTH);
            r_height <= bmf_pkg::DIM_W'(bmf_pkg::MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bmf_pkg::CFG_MODE:   r_mode   <= i_cfg_data[0];
                bmf_pkg::CFG_WIDTH:  r_width  <= n_dim;
                bmf_pkg::CFG_HEIGHT: r_height <= n_dim;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_bit      <= cur_bit && in_frame;
            r_s1_emit     <= emit;
            r_s1_last     <= is_last;
            r_s1_top_ok   <= (r_out_row != '0);
            r_s1_bot_ok   <= ({1'b0, r_out_row} != r_height - 1'b1);
            r_s1_left_ok  <= (r_out_col != '0);
            r_s1_right_ok <= ({1'b0, r_out_col} != r_width - 1'b1);
        end
    end

    // window evaluation
    assign s1_fire = r_s1_valid && s1_go;
    assign win_r   = {r_s1_bit, rd_mid, rd_top};
    assign row_m   = {r_s1_bot_ok, 1'b1, r_s1_top_ok};
    assign m_l     = row_m & {3{r_s1_left_ok}};
    assign m_r     = row_m & {3{r_s1_right_ok}};
    assign all_set = (&(r_win_l | ~m_l)) && (&(r_win_c | ~row_m)) && (&(win_r | ~m_r));
    assign any_set = (|(r_win_l & m_l)) || (|(r_win_c & row_m)) || (|(win_r & m_r));
    assign win_res = (r_mode == bmf_pkg::MODE_DILATE) ? any_set : all_set;

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_win_l <= r_win_c;
            r_win_c <= win_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data.out_pixel     <= win_res ? bmf_pkg::PIX_ONE : bmf_pkg::PIX_ZERO;
            r_out_data.last_of_frame <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `BMF_ASSERT_IMP(a_pixel_binary, i_clk, i_rst_n, o_out_valid, (o_out_data.out_pixel == bmf_pkg::PIX_ONE || o_out_data.out_pixel == bmf_pkg::PIX_ZERO))
    `BMF_ASSERT_IMP(a_col_in_range, i_clk, i_rst_n, 1'b1, ({1'b0, r_in_col} < r_width))
    `BMF_ASSERT_NXT(a_last_restarts, i_clk, i_rst_n, (adv && is_last), (r_in_row == '0 && r_in_col == '0 && r_out_row == '0 && r_out_col == '0))
    `BMF_ASSERT_NXT(a_s1_holds, i_clk, i_rst_n, (r_s1_valid && !s1_go), (r_s1_valid && $stable(r_s1_last) && $stable(r_s1_emit)))

endmodule
